// ----- hdl/cmm_pkg.sv -----
package cmm_pkg;

  // Fixed lane count of the item format
  localparam int LANES = 8;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W = 16;
  localparam int COUNT_W = 4;
  localparam int LANE_IDX_W = 3;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int QUAD_W = PROD_W + 2;
  localparam int SUM_W = PROD_W + 3;
  localparam int FRAC_SHIFT = 12;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 2'd2;

  // Item opcodes
  localparam logic OP_MIX = 1'b0;
  localparam logic OP_COEF = 1'b1;

  // Gains in Q3.12
  localparam logic signed [COEF_W-1:0] GAIN_UNITY = 16'sd4096;
  localparam logic signed [COEF_W-1:0] GAIN_HALF_POWER = 16'sd2896;
  localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W+1)'(2048);

  // Fixed stereo to 5.1 channel counts
  localparam logic [COUNT_W-1:0] ST51_IN = 4'd2;
  localparam logic [COUNT_W-1:0] ST51_OUT = 4'd6;

  // Reset value of the channel count registers
  localparam logic [COUNT_W-1:0] RST_CHANNELS = 4'd2;

  typedef enum logic [1:0] {
    MODE_CUSTOM   = 2'd0,
    MODE_IDENTITY = 2'd1,
    MODE_ST51     = 2'd2
  } mix_mode_t;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
    logic [LANE_IDX_W-1:0]      coef_row;
    logic [LANE_IDX_W-1:0]      coef_col;
    logic signed [COEF_W-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_0;
    logic signed [SAMPLE_W-1:0] out_1;
    logic signed [SAMPLE_W-1:0] out_2;
    logic signed [SAMPLE_W-1:0] out_3;
    logic signed [SAMPLE_W-1:0] out_4;
    logic signed [SAMPLE_W-1:0] out_5;
    logic signed [SAMPLE_W-1:0] out_6;
    logic signed [SAMPLE_W-1:0] out_7;
  } out_item_t;

  // Per-stage load enables shared by all lanes
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } stage_en_t;

  // Coefficient write broadcast to the lanes
  typedef struct packed {
    logic                     we;
    logic [LANE_IDX_W-1:0]    row;
    logic [LANE_IDX_W-1:0]    col;
    logic signed [COEF_W-1:0] value;
  } coef_wr_t;

  // Gain table of the fixed stereo to 5.1 matrix (L, R, C, LFE, Ls, Rs)
  function automatic logic signed [COEF_W-1:0] st51_gain(
    logic [LANE_IDX_W-1:0] o,
    logic [LANE_IDX_W-1:0] i
  );
    logic signed [COEF_W-1:0] g;
    g = '0;
    if (o == 3'd0 && i == 3'd0) g = GAIN_UNITY;
    else if (o == 3'd1 && i == 3'd1) g = GAIN_UNITY;
    else if (o == 3'd2) g = GAIN_HALF_POWER;
    else if (o == 3'd4 && i == 3'd0) g = GAIN_HALF_POWER;
    else if (o == 3'd5 && i == 3'd1) g = GAIN_HALF_POWER;
    return g;
  endfunction

endpackage

// ----- hdl/cmm_lane.sv -----
module cmm_lane #(
  parameter int LANE = 0,
  parameter int NUM_IN = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmm_pkg::stage_en_t                stg_en,
  input  cmm_pkg::coef_wr_t                 coef_wr,
  input  cmm_pkg::mix_mode_t                mode,
  input  logic [cmm_pkg::LANES-1:0]         in_mask,
  input  logic                              lane_on,
  input  logic signed [cmm_pkg::SAMPLE_W-1:0] samples [cmm_pkg::LANES],
  output logic signed [cmm_pkg::SAMPLE_W-1:0] result
);
  import cmm_pkg::*;

  localparam logic [LANE_IDX_W-1:0] LANE_ID = LANE_IDX_W'(LANE);

  logic signed [COEF_W-1:0] coef [NUM_IN];
  logic signed [COEF_W-1:0] gain [LANES];
  logic signed [PROD_W-1:0] prod [LANES];
  logic signed [PAIR_W-1:0] pair [LANES/2];
  logic signed [QUAD_W-1:0] quad [LANES/4];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W:0]    rounded;
  logic signed [SUM_W-FRAC_SHIFT:0] scaled;
  logic signed [SAMPLE_W-1:0] sat;

  for (genvar i = 0; i < LANES; i++) begin : g_tap
    if (i < NUM_IN) begin : g_used
      // Coefficient row of this output channel
      always_ff @(posedge clk) begin
        if (rst) begin
          coef[i] <= '0;
        end else if (coef_wr.we && coef_wr.row == LANE_ID &&
                     coef_wr.col == LANE_IDX_W'(i)) begin
          coef[i] <= coef_wr.value;
        end
      end

      // Gain for this tap; unused inputs and idle lanes weigh zero
      always_comb begin
        gain[i] = '0;
        if (lane_on && in_mask[i]) begin
          case (mode)
            MODE_CUSTOM:   gain[i] = coef[i];
            MODE_IDENTITY: gain[i] = (LANE == i) ? GAIN_UNITY : '0;
            MODE_ST51:     gain[i] = st51_gain(LANE_ID, LANE_IDX_W'(i));
            default:       gain[i] = '0;
          endcase
        end
      end

      // Stage 1: one product per tap
      always_ff @(posedge clk) begin
        if (stg_en.en1) begin
          prod[i] <= gain[i] * samples[i];
        end
      end
    end else begin : g_unused
      assign gain[i] = '0;
      assign prod[i] = '0;
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (stg_en.en2) begin
      for (int k = 0; k < LANES/2; k++) begin
        pair[k] <= PAIR_W'(prod[2*k]) + PAIR_W'(prod[2*k+1]);
      end
    end
  end

  // Stage 3: sums of four
  always_ff @(posedge clk) begin
    if (stg_en.en3) begin
      for (int k = 0; k < LANES/4; k++) begin
        quad[k] <= QUAD_W'(pair[2*k]) + QUAD_W'(pair[2*k+1]);
      end
    end
  end

  // Stage 4: full sum
  always_ff @(posedge clk) begin
    if (stg_en.en4) begin
      total <= SUM_W'(quad[0]) + SUM_W'(quad[1]);
    end
  end

  // Round half up to Q1.15, then saturate
  always_comb begin
    rounded = (SUM_W+1)'(total) + ROUND_HALF;
    scaled = rounded[SUM_W:FRAC_SHIFT];
    if (scaled > (SUM_W-FRAC_SHIFT+1)'(32767)) begin
      sat = 16'sh7fff;
    end else if (scaled < -(SUM_W-FRAC_SHIFT+1)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = scaled[SAMPLE_W-1:0];
    end
  end

  // Stage 5: lane result register
  always_ff @(posedge clk) begin
    if (stg_en.en5) begin
      result <= sat;
    end
  end

endmodule

// ----- hdl/channel_mix_matrix.sv -----
// Channel   Handshake             Payload
// in        in_valid / in_ready   in_data   (frame or coefficient item)
// out       out_valid / out_ready out_data  (mixed frame)
// cfg       cfg_we                cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds. An accepted frame
// passes the input register, products, three adder-tree levels, then
// rounding and saturation into the output register, which drives out_valid.
// Coefficient items update the lane coefficient registers at acceptance and
// leave no result. Reset is synchronous and clears the coefficient store.
// A stalled output backs the pipeline up stage by stage; bubbles collapse.
module channel_mix_matrix #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cmm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cmm_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [cmm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cmm_pkg::*;

  localparam int NSTG = 6;
  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_CHANNELS);

  logic [1:0]         mix_mode;
  logic [COUNT_W-1:0] in_channels;
  logic [COUNT_W-1:0] out_channels;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic            in_acc;

  in_item_t   s0_item;
  mix_mode_t  mode;
  logic [COUNT_W-1:0] n_in;
  logic [COUNT_W-1:0] n_out;
  logic [LANES-1:0]   in_mask;
  logic [LANES-1:0]   out_mask;
  logic signed [SAMPLE_W-1:0] samples [LANES];
  logic signed [SAMPLE_W-1:0] lane_out [LANES];
  stage_en_t stg_en;
  coef_wr_t  coef_wr;

  function automatic logic [COUNT_W-1:0] clamp_n(logic [COUNT_W-1:0] n);
    return (n > MAX_N) ? MAX_N : n;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode <= MODE_IDENTITY;
      in_channels <= RST_CHANNELS;
      out_channels <= RST_CHANNELS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIX_MODE:     mix_mode <= cfg_data[1:0];
        REG_IN_CHANNELS:  in_channels <= cfg_data;
        REG_OUT_CHANNELS: out_channels <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elastic pipeline control: a stage loads when empty or when it drains
  always_comb begin
    rdy[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];
  assign in_acc = in_valid && in_ready;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_acc && in_data.op == OP_MIX;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign stg_en.en1 = rdy[1] && vld[0];
  assign stg_en.en2 = rdy[2] && vld[1];
  assign stg_en.en3 = rdy[3] && vld[2];
  assign stg_en.en4 = rdy[4] && vld[3];
  assign stg_en.en5 = rdy[5] && vld[4];

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == OP_MIX) begin
      s0_item <= in_data;
    end
  end

  // Coefficient writes go straight to the lanes at acceptance
  assign coef_wr.we = in_acc && in_data.op == OP_COEF;
  assign coef_wr.row = in_data.coef_row;
  assign coef_wr.col = in_data.coef_col;
  assign coef_wr.value = in_data.coef_value;

  // Channel counts per mode
  always_comb begin
    mode = mix_mode_t'(mix_mode);
    unique case (mix_mode)
      MODE_CUSTOM: begin
        n_in = clamp_n(in_channels);
        n_out = clamp_n(out_channels);
      end
      MODE_IDENTITY: begin
        n_in = clamp_n(in_channels);
        n_out = clamp_n(in_channels);
      end
      MODE_ST51: begin
        n_in = clamp_n(ST51_IN);
        n_out = clamp_n(ST51_OUT);
      end
      default: begin
        n_in = '0;
        n_out = '0;
      end
    endcase
    for (int k = 0; k < LANES; k++) begin
      in_mask[k] = COUNT_W'(k) < n_in;
      out_mask[k] = COUNT_W'(k) < n_out;
    end
  end

  assign samples[0] = s0_item.sample_0;
  assign samples[1] = s0_item.sample_1;
  assign samples[2] = s0_item.sample_2;
  assign samples[3] = s0_item.sample_3;
  assign samples[4] = s0_item.sample_4;
  assign samples[5] = s0_item.sample_5;
  assign samples[6] = s0_item.sample_6;
  assign samples[7] = s0_item.sample_7;

  // One lane per output channel
  for (genvar o = 0; o < LANES; o++) begin : g_lane
    if (o < MAX_CHANNELS) begin : g_on
      cmm_lane #(
        .LANE   (o),
        .NUM_IN (MAX_CHANNELS)
      ) u_lane (
        .clk     (clk),
        .rst     (rst),
        .stg_en  (stg_en),
        .coef_wr (coef_wr),
        .mode    (mode),
        .in_mask (in_mask),
        .lane_on (out_mask[o]),
        .samples (samples),
        .result  (lane_out[o])
      );
    end else begin : g_off
      assign lane_out[o] = '0;
    end
  end

  // Merge lane results into the output item
  assign out_data.out_0 = lane_out[0];
  assign out_data.out_1 = lane_out[1];
  assign out_data.out_2 = lane_out[2];
  assign out_data.out_3 = lane_out[3];
  assign out_data.out_4 = lane_out[4];
  assign out_data.out_5 = lane_out[5];
  assign out_data.out_6 = lane_out[6];
  assign out_data.out_7 = lane_out[7];

`ifndef NO_ASSERTIONS
  // A coefficient item never enters the pipeline
  a_coef_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_data.op == OP_COEF |=> !vld[0])
    else $error("coefficient item entered the mix pipeline");

  // A frame item always enters stage zero
  a_frame_enters: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_data.op == OP_MIX |=> vld[0])
    else $error("frame item lost at input");

  // Input backpressure only when every stage is full and the output stalls
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld) && !out_ready)
    else $error("input stalled with room in the pipeline");

  // Reset empties the pipeline and restores the default mode
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !vld[0] && mix_mode == MODE_IDENTITY)
    else $error("reset state wrong");
`endif

endmodule

// ----- test/tb_channel_mix_matrix.sv -----
module tb_channel_mix_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  import cmm_pkg::*;

  localparam int PIPE_LATENCY = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int PRINT_CAP = 50;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 75;
  localparam int MAX_LANES = 8;
  localparam int UNITY_Q12 = 4096;
  localparam int HALF_POWER_Q12 = 2896;
  localparam int ST51_INPUTS = 2;
  localparam int ST51_OUTPUTS = 6;
  localparam longint HALF_LSB = 2048;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers and coefficient store
  logic [1:0] mode_now = MODE_IDENTITY;
  logic [3:0] in_ch_now = 4'd2;
  logic [3:0] out_ch_now = 4'd2;
  logic signed [COEF_W-1:0] gain_store [64];

  in_item_t pending_items [$];
  out_item_t expected_frames [$];

  logic in_took = 1'b0;
  logic stall_hold = 1'b0;
  logic hold_request = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int frames_checked = 0;
  int coef_writes = 0;
  int cycle_count = 0;

  channel_mix_matrix dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int limit_count(logic [3:0] n);
    return (n > MAX_LANES) ? MAX_LANES : int'(n);
  endfunction

  // Fixed stereo to 5.1 gains, output order L R C LFE Ls Rs
  function automatic int fixed_gain(int o, int i);
    case (o)
      0: return (i == 0) ? UNITY_Q12 : 0;
      1: return (i == 1) ? UNITY_Q12 : 0;
      2: return HALF_POWER_Q12;
      4: return (i == 0) ? HALF_POWER_Q12 : 0;
      5: return (i == 1) ? HALF_POWER_Q12 : 0;
      default: return 0;
    endcase
  endfunction

  // Expected mixed frame for one sample item under the current settings.
  // Lane k of an out_item_t sits at bits [127-16k -: 16].
  function automatic out_item_t mix_frame(in_item_t x);
    int smp [MAX_LANES];
    int n_in;
    int n_out;
    int g;
    longint acc;
    longint q;
    out_item_t res;
    smp[0] = int'(x.sample_0);
    smp[1] = int'(x.sample_1);
    smp[2] = int'(x.sample_2);
    smp[3] = int'(x.sample_3);
    smp[4] = int'(x.sample_4);
    smp[5] = int'(x.sample_5);
    smp[6] = int'(x.sample_6);
    smp[7] = int'(x.sample_7);
    n_in = 0;
    n_out = 0;
    case (mode_now)
      MODE_CUSTOM: begin
        n_in = limit_count(in_ch_now);
        n_out = limit_count(out_ch_now);
      end
      MODE_IDENTITY: begin
        n_in = limit_count(in_ch_now);
        n_out = n_in;
      end
      MODE_ST51: begin
        n_in = ST51_INPUTS;
        n_out = ST51_OUTPUTS;
      end
      default: ;
    endcase
    res = '0;
    for (int o = 0; o < n_out; o++) begin
      acc = 0;
      for (int i = 0; i < n_in; i++) begin
        case (mode_now)
          MODE_CUSTOM: g = int'(gain_store[o * 8 + i]);
          MODE_IDENTITY: g = (o == i) ? UNITY_Q12 : 0;
          default: g = fixed_gain(o, i);
        endcase
        acc += longint'(g) * longint'(smp[i]);
      end
      // round half up, then clamp to Q1.15
      q = (acc + HALF_LSB) >>> FRAC_SHIFT;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      res[127 - 16 * o -: 16] = q[15:0];
    end
    return res;
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_item(int coef_pct);
    in_item_t x;
    x.op = ($urandom_range(99) < coef_pct) ? OP_COEF : OP_MIX;
    x.sample_0 = random_sample();
    x.sample_1 = random_sample();
    x.sample_2 = random_sample();
    x.sample_3 = random_sample();
    x.sample_4 = random_sample();
    x.sample_5 = random_sample();
    x.sample_6 = random_sample();
    x.sample_7 = random_sample();
    x.coef_row = 3'($urandom_range(7));
    x.coef_col = 3'($urandom_range(7));
    // mostly modest gains so that sums do not always clip
    case ($urandom_range(9))
      0: x.coef_value = 16'sh7FFF;
      1: x.coef_value = 16'sh8000;
      2, 3, 4, 5: x.coef_value = 16'($urandom_range(2048)) - 16'sd1024;
      6: x.coef_value = '0;
      default: x.coef_value = 16'($urandom);
    endcase
    return x;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Even lanes get one value, odd lanes the other
  task automatic queue_frame(input int even_val, input int odd_val);
    in_item_t x;
    x = random_item(0);
    x.sample_0 = 16'(even_val);
    x.sample_1 = 16'(odd_val);
    x.sample_2 = 16'(even_val);
    x.sample_3 = 16'(odd_val);
    x.sample_4 = 16'(even_val);
    x.sample_5 = 16'(odd_val);
    x.sample_6 = 16'(even_val);
    x.sample_7 = 16'(odd_val);
    pending_items.push_back(x);
  endtask

  task automatic queue_coef(input int row, input int col, input int value);
    in_item_t x;
    x = random_item(100);
    x.coef_row = 3'(row);
    x.coef_col = 3'(col);
    x.coef_value = 16'(value);
    pending_items.push_back(x);
  endtask

  // Register write while the block is idle; shadow copy follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIX_MODE: mode_now = val[1:0];
      REG_IN_CHANNELS: in_ch_now = val;
      REG_OUT_CHANNELS: out_ch_now = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [3:0] n_in, input logic [3:0] n_out);
    write_reg(REG_MIX_MODE, {2'b00, mode});
    write_reg(REG_IN_CHANNELS, n_in);
    write_reg(REG_OUT_CHANNELS, n_out);
  endtask

  // Everything sent and answered, then let a coefficient item settle too
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  // Item sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off so the pipeline backs up into the input
  initial begin
    wait (hold_request);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold <= 1'b0;
  end

  // Check results against the oldest expectation, then predict new items
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_frames.pop_front();
          for (int k = 0; k < MAX_LANES; k++) begin
            if (out_data[127 - 16 * k -: 16] !== want[127 - 16 * k -: 16])
              report_mismatch($sformatf("frame %0d out_%0d got %0d want %0d",
                frames_checked, k, $signed(out_data[127 - 16 * k -: 16]),
                $signed(want[127 - 16 * k -: 16])));
          end
          frames_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == OP_COEF) begin
          gain_store[{in_data.coef_row, in_data.coef_col}] = in_data.coef_value;
          coef_writes++;
        end else begin
          expected_frames.push_back(mix_frame(in_data));
        end
      end
      in_took <= in_valid && in_ready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
        cycle_count, expected_frames.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int coef_pct;
    for (int k = 0; k < 64; k++) gain_store[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: identity over two channels, sample extremes
    queue_frame(32767, -32768);
    queue_frame(-1, 0);
    queue_frame(21845, -21846);
    // coefficient writes outside custom mode still land in the store
    queue_coef(0, 0, 32767);
    queue_coef(1, 1, -32768);
    queue_coef(2, 0, 1);
    queue_coef(3, 7, -1);
    queue_coef(7, 7, 4096);
    queue_coef(6, 3, -4096);
    queue_frame(12345, -12345);
    wait_idle();

    // Custom full matrix: clipping both ways, rounding of half an LSB
    configure(MODE_CUSTOM, 4'd8, 4'd8);
    queue_frame(32767, 32767);
    queue_frame(2048, -2048);
    queue_frame(-2048, 2048);
    wait_idle();

    // Zero and oversized channel counts
    configure(MODE_CUSTOM, 4'd0, 4'd8);
    queue_frame(32767, -32768);
    wait_idle();
    configure(MODE_CUSTOM, 4'd15, 4'd0);
    queue_frame(32767, -32768);
    wait_idle();
    configure(MODE_CUSTOM, 4'd15, 4'd15);
    queue_frame(-32768, 32767);
    wait_idle();
    configure(MODE_IDENTITY, 4'd15, 4'd1);
    queue_frame(-32768, 32767);
    wait_idle();

    // Fixed upmix ignores the channel registers; center clips at full scale
    configure(MODE_ST51, 4'd0, 4'd0);
    queue_frame(32767, 32767);
    queue_frame(-32768, -32768);
    queue_frame(10000, -10000);
    wait_idle();

    // Unused mode value gives an all-zero frame
    configure(MODE_UNUSED, 4'd8, 4'd8);
    queue_frame(32767, -1);
    wait_idle();

    // Write to the unused register index must change nothing
    write_reg(REG_MIX_MODE, {2'b00, MODE_IDENTITY});
    write_reg(REG_UNUSED, 4'hF);
    queue_frame(1000, -1000);
    wait_idle();

    // Random phases over settings and handshake pressure profiles
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 6)
        0: configure(MODE_CUSTOM, 4'd8, 4'd8);
        1: configure(MODE_CUSTOM, 4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)));
        2: configure(MODE_IDENTITY, 4'($urandom_range(1, 8)), 4'($urandom_range(15)));
        3: configure(MODE_ST51, 4'($urandom_range(15)), 4'($urandom_range(15)));
        4: configure(MODE_CUSTOM, 4'd1, 4'd1);
        default: configure(2'($urandom_range(2)), 4'($urandom_range(15)),
          4'($urandom_range(15)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 52; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 52; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      coef_pct = (mode_now == MODE_CUSTOM) ? 30 : 15;
      if (p == 0) hold_request = 1'b1;
      repeat (PHASE_ITEMS) pending_items.push_back(random_item(coef_pct));
      wait_idle();
    end

    $display("Checked %0d mixed frames and applied %0d coefficient writes in %0d cycles.",
      frames_checked, coef_writes, cycle_count);
    $display("Covered every mix mode, channel counts 0 to 15, clipping, rounding and a long output stall.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cmm_pkg.sv
hdl/cmm_lane.sv
hdl/channel_mix_matrix.sv
test/tb_channel_mix_matrix.sv
